// ----- hdl/plc_pkg.sv -----
// plc_pkg: shared types and constants of the phong light accumulator
// command and status structs between controller and datapath, field widths
// no dependencies
package plc_pkg;

    // field widths
    localparam int COMP_W   = 16;
    localparam int VEC_W    = 48;
    localparam int LEVEL_W  = 16;
    localparam int EXP_W    = 10;
    localparam int SUM_W    = 24;
    localparam int RAD_W    = 34;
    localparam int ROOT_W   = 17;
    localparam int QUO_W    = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // q1.14 one
    localparam logic [QUO_W-1:0] Q_ONE = 15'd16384;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 1'd1;

    // unit vector targets
    localparam logic [1:0] TGT_N = 2'd0;
    localparam logic [1:0] TGT_V = 2'd1;
    localparam logic [1:0] TGT_L = 2'd2;

    // request types
    localparam logic REQ_SHADE = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    // light kinds
    localparam logic KIND_POINT = 1'b0;

    typedef struct packed {
        logic       ld_shade;
        logic       ld_load;
        logic       wv_view;
        logic       wv_light;
        logic       rd_en;
        logic       sq_acc;
        logic       sqrt_start;
        logic       div_start;
        logic       div_store;
        logic       dot_acc;
        logic       cs_mul;
        logic       cs_fin;
        logic       pwr_step;
        logic       term1;
        logic       term2;
        logic       set_degen;
        logic       out_ld;
        logic [1:0] comp;
        logic [1:0] target;
        logic [3:0] dstep;
    } cmd_t;

    typedef struct packed {
        logic s_zero;
        logic sqrt_busy;
        logic div_busy;
        logic e_zero;
    } sts_t;

    // one signed component of a packed x,y,z vector
    function automatic logic signed [COMP_W-1:0] vcomp(input logic [VEC_W-1:0] v,
                                                       input logic [1:0] i);
        logic [COMP_W-1:0] r;
        r = v[COMP_W*i +: COMP_W];
        return $signed(r);
    endfunction

endpackage

// ----- hdl/plc_sqrt.sv -----
// plc_sqrt: iterative integer square root, two radicand bits per cycle
// depends on plc_pkg
module plc_sqrt
    import plc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [4:0]        cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_t;
    logic [REM_W+1:0]  trial;

    assign rem_t = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 5'(ROOT_W);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 5'd1;
    end

    // one root digit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_t >= trial)
            begin
                rem_reg  <= REM_W'(rem_t - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_t);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;

endmodule

// ----- hdl/plc_div.sv -----
// plc_div: restoring divider, (mag * 2^14) / den, one quotient bit per cycle
// quotient known to stay below 2^15; depends on plc_pkg
module plc_div
    import plc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [COMP_W-1:0] mag,
    input  logic [ROOT_W-1:0] den,
    output logic              busy,
    output logic [QUO_W-1:0]  quo
);

    logic [3:0]        cnt_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [QUO_W-1:0]  lo_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [ROOT_W:0]   t;

    assign t = {rem_reg, lo_reg[QUO_W-1]};

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 4'(QUO_W);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 4'd1;
    end

    // numerator high part starts as remainder, low bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, mag[COMP_W-1:1]};
            lo_reg  <= {mag[0], 14'd0};
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            lo_reg <= {lo_reg[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, den})
            begin
                rem_reg <= ROOT_W'(t - {1'b0, den});
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= t[ROOT_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

// ----- hdl/plc_dpath.sv -----
// plc_dpath: datapath with light table, vector registers, dot products,
// specular power and accumulator; depends on plc_pkg, plc_sqrt, plc_div
module plc_dpath
    import plc_pkg::*;
#(
    parameter int LIGHTS = 8,
    parameter int IDX_W  = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [2:0]            light_slot,
    input  logic                  light_kind,
    input  logic [LEVEL_W-1:0]    light_level,
    input  logic [VEC_W-1:0]      vector_a,
    input  logic [VEC_W-1:0]      surface_normal,
    input  logic [VEC_W-1:0]      view_vector,
    input  logic [EXP_W-1:0]      shininess,
    output logic [LEVEL_W-1:0]    total_light,
    output logic                  clipped,
    output logic                  degenerate
);

    // light table
    logic [VEC_W-1:0]   tvec_mem [LIGHTS];
    logic [LEVEL_W:0]   tpar_mem [LIGHTS];
    logic [VEC_W-1:0]   rdv_reg;
    logic [LEVEL_W:0]   rdp_reg;

    logic [CFG_W-1:0]   ambient_reg;
    logic [VEC_W-1:0]   pt_reg;
    logic [VEC_W-1:0]   view_reg;
    logic [EXP_W-1:0]   shin_reg;

    logic signed [COMP_W:0]   wv_reg [3];
    logic signed [COMP_W-1:0] nu_reg [3];
    logic signed [COMP_W-1:0] vu_reg [3];
    logic signed [COMP_W-1:0] lu_reg [3];
    logic [RAD_W-1:0]         s_reg;
    logic signed [31:0]       dnl_reg;
    logic signed [31:0]       dnv_reg;
    logic signed [31:0]       dlv_reg;
    logic signed [63:0]       prod_reg;
    logic [QUO_W-1:0]         cd_reg;
    logic [QUO_W-1:0]         r_reg;
    logic [QUO_W-1:0]         b_reg;
    logic [EXP_W-1:0]         e_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     degen_reg;
    logic [LEVEL_W-1:0]       tot_reg;
    logic                     clip_reg;
    logic                     dgn_reg;

    logic                     tbl_wr;
    logic signed [COMP_W:0]   wsel;
    logic signed [2*COMP_W+1:0] sq_prod;
    logic [COMP_W:0]          mag17;
    logic [ROOT_W-1:0]        root;
    logic [QUO_W-1:0]         quo;
    logic signed [COMP_W-1:0] unit_c;
    logic signed [COMP_W-1:0] da;
    logic signed [COMP_W-1:0] db;
    logic signed [31:0]       dprod;
    logic signed [63:0]       cs;
    logic [17:0]              cd_raw;
    logic [21:0]              c_raw;
    logic [QUO_W-1:0]         cd_cap;
    logic [QUO_W-1:0]         c_cap;
    logic [2*QUO_W-1:0]       rb;
    logic [2*QUO_W-1:0]       bb;
    logic [QUO_W-1:0]         tm_b;
    logic [LEVEL_W+QUO_W-1:0] tprod;

    // table write and registered read
    assign tbl_wr = cmd.ld_load && (int'(light_slot) < LIGHTS);

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            tvec_mem[IDX_W'(light_slot)] <= vector_a;
            tpar_mem[IDX_W'(light_slot)] <= {light_kind, light_level};
        end
        if (cmd.rd_en)
        begin
            rdv_reg <= tvec_mem[rd_addr];
            rdp_reg <= tpar_mem[rd_addr];
        end
    end

    // ambient register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ambient_reg <= '0;
        else if (cfg_wr_en && cfg_index == REG_AMBIENT)
            ambient_reg <= cfg_data;
    end

    // square of one work component
    assign wsel    = wv_reg[cmd.comp];
    assign sq_prod = wsel * wsel;
    assign mag17   = wsel[COMP_W] ? COMP_W'(0) - wsel : wsel;

    // shared iterative units
    plc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (s_reg),
        .busy     (sts.sqrt_busy),
        .root     (root)
    );

    plc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .mag   (mag17[COMP_W-1:0]),
        .den   (root),
        .busy  (sts.div_busy),
        .quo   (quo)
    );

    assign unit_c = wsel[COMP_W] ? COMP_W'(0) - $signed({1'b0, quo})
                                 : $signed({1'b0, quo});

    // dot product operand select
    always_comb
    begin
        case (cmd.dstep)
            4'd0: begin da = nu_reg[0]; db = lu_reg[0]; end
            4'd1: begin da = nu_reg[1]; db = lu_reg[1]; end
            4'd2: begin da = nu_reg[2]; db = lu_reg[2]; end
            4'd3: begin da = nu_reg[0]; db = vu_reg[0]; end
            4'd4: begin da = nu_reg[1]; db = vu_reg[1]; end
            4'd5: begin da = nu_reg[2]; db = vu_reg[2]; end
            4'd6: begin da = lu_reg[0]; db = vu_reg[0]; end
            4'd7: begin da = lu_reg[1]; db = vu_reg[1]; end
            4'd8: begin da = lu_reg[2]; db = vu_reg[2]; end
            default: begin da = '0; db = '0; end
        endcase
    end

    assign dprod = da * db;

    // specular cosine at scale 2^56, diffuse and specular caps
    assign cs     = (prod_reg <<< 1) - ({{32{dlv_reg[31]}}, dlv_reg} <<< 28);
    assign cd_raw = dnl_reg[31:14];
    assign c_raw  = cs[63:42];
    assign cd_cap = (cd_raw > 18'(Q_ONE)) ? Q_ONE : cd_raw[QUO_W-1:0];
    assign c_cap  = (c_raw > 22'(Q_ONE)) ? Q_ONE : c_raw[QUO_W-1:0];

    // power step and intensity product
    assign rb    = r_reg * b_reg;
    assign bb    = b_reg * b_reg;
    assign tm_b  = cmd.term2 ? r_reg : cd_reg;
    assign tprod = rdp_reg[LEVEL_W-1:0] * tm_b;

    // work and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_shade)
        begin
            pt_reg   <= vector_a;
            view_reg <= view_vector;
            shin_reg <= shininess;
            for (int i = 0; i < 3; i++)
                wv_reg[i] <= (COMP_W+1)'(vcomp(surface_normal, 2'(i)));
        end
        else if (cmd.wv_view)
        begin
            for (int i = 0; i < 3; i++)
                wv_reg[i] <= (COMP_W+1)'(vcomp(view_reg, 2'(i)));
        end
        else if (cmd.wv_light)
        begin
            for (int i = 0; i < 3; i++)
                wv_reg[i] <= (rdp_reg[LEVEL_W] == KIND_POINT)
                    ? (COMP_W+1)'(vcomp(rdv_reg, 2'(i))) - (COMP_W+1)'(vcomp(pt_reg, 2'(i)))
                    : (COMP_W+1)'(vcomp(rdv_reg, 2'(i)));
        end

        // sum of squares
        if (cmd.sq_acc)
            s_reg <= (cmd.comp == 2'd0) ? RAD_W'($unsigned(sq_prod))
                                        : s_reg + RAD_W'($unsigned(sq_prod));

        // store one unit component
        if (cmd.div_store)
        begin
            case (cmd.target)
                TGT_N:   nu_reg[cmd.comp] <= unit_c;
                TGT_V:   vu_reg[cmd.comp] <= unit_c;
                TGT_L:   lu_reg[cmd.comp] <= unit_c;
                default: lu_reg[cmd.comp] <= unit_c;
            endcase
        end

        // dot accumulators, first product of each dot loads
        if (cmd.dot_acc)
        begin
            case (cmd.dstep)
                4'd0:    dnl_reg <= dprod;
                4'd1,
                4'd2:    dnl_reg <= dnl_reg + dprod;
                4'd3:    dnv_reg <= dprod;
                4'd4,
                4'd5:    dnv_reg <= dnv_reg + dprod;
                4'd6:    dlv_reg <= dprod;
                default: dlv_reg <= dlv_reg + dprod;
            endcase
        end

        if (cmd.cs_mul)
            prod_reg <= dnl_reg * dnv_reg;

        // set up diffuse cosine and power loop
        if (cmd.cs_fin)
        begin
            cd_reg <= (dnl_reg > 0) ? cd_cap : '0;
            b_reg  <= c_cap;
            if (cs > 0)
            begin
                r_reg <= Q_ONE;
                e_reg <= shin_reg;
            end
            else
            begin
                r_reg <= '0;
                e_reg <= '0;
            end
        end
        else if (cmd.pwr_step)
        begin
            if (e_reg[0])
                r_reg <= rb[28:14];
            b_reg <= bb[28:14];
            e_reg <= e_reg >> 1;
        end

        // accumulator
        if (cmd.ld_shade)
            sum_reg <= SUM_W'(ambient_reg);
        else if (cmd.ld_load)
            sum_reg <= '0;
        else if (cmd.term1 || cmd.term2)
            sum_reg <= sum_reg + SUM_W'(tprod[LEVEL_W+QUO_W-1:14]);

        if (cmd.ld_shade || cmd.ld_load)
            degen_reg <= 1'b0;
        else if (cmd.set_degen)
            degen_reg <= 1'b1;

        // output beat with saturation
        if (cmd.out_ld)
        begin
            if (sum_reg > SUM_W'(16'hFFFF))
            begin
                tot_reg  <= 16'hFFFF;
                clip_reg <= 1'b1;
            end
            else
            begin
                tot_reg  <= sum_reg[LEVEL_W-1:0];
                clip_reg <= 1'b0;
            end
            dgn_reg <= degen_reg;
        end
    end

    assign sts.s_zero = s_reg == '0;
    assign sts.e_zero = e_reg == '0;

    assign total_light = tot_reg;
    assign clipped     = clip_reg;
    assign degenerate  = dgn_reg;

endmodule

// ----- hdl/plc_ctrl.sv -----
// plc_ctrl: controller state machine, light loop and handshakes
// depends on plc_pkg
module plc_ctrl
    import plc_pkg::*;
#(
    parameter int LIGHTS = 8,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cmd_t                 cmd,
    input  sts_t                 sts,
    output logic [IDX_W-1:0]     rd_addr
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_USQ   = 4'd1;
    localparam logic [3:0] S_UCHK  = 4'd2;
    localparam logic [3:0] S_USQRT = 4'd3;
    localparam logic [3:0] S_UDIV  = 4'd4;
    localparam logic [3:0] S_UDIVW = 4'd5;
    localparam logic [3:0] S_VLD   = 4'd6;
    localparam logic [3:0] S_LNEXT = 4'd7;
    localparam logic [3:0] S_LRD   = 4'd8;
    localparam logic [3:0] S_DOT   = 4'd9;
    localparam logic [3:0] S_CSM   = 4'd10;
    localparam logic [3:0] S_CSF   = 4'd11;
    localparam logic [3:0] S_PWR   = 4'd12;
    localparam logic [3:0] S_T1    = 4'd13;
    localparam logic [3:0] S_T2    = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]       state_reg,  state_next;
    logic [1:0]       comp_reg,   comp_next;
    logic [1:0]       tgt_reg,    tgt_next;
    logic [3:0]       dstep_reg,  dstep_next;
    logic [CNT_W-1:0] k_reg,      k_next;
    logic             nok_reg,    nok_next;
    logic             vok_reg,    vok_next;
    logic             ov_reg,     ov_next;
    logic [3:0]       active_reg;
    logic [CNT_W-1:0] lim;
    logic             out_free;

    // light count clamped to the table
    always_comb
    begin
        if (int'(active_reg) > LIGHTS)
            lim = CNT_W'(LIGHTS);
        else
            lim = CNT_W'(active_reg);
    end

    assign out_free = !ov_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        tgt_next   = tgt_reg;
        dstep_next = dstep_reg;
        k_next     = k_reg;
        nok_next   = nok_reg;
        vok_next   = vok_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.target = tgt_reg;
        cmd.dstep  = dstep_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.ld_load = 1'b1;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        cmd.ld_shade = 1'b1;
                        nok_next     = 1'b1;
                        vok_next     = 1'b1;
                        comp_next    = 2'd0;
                        tgt_next     = TGT_N;
                        state_next   = S_USQ;
                    end
                end
            end

            // sum of squares, one component a cycle
            S_USQ:
            begin
                cmd.sq_acc = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = S_UCHK;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end

            S_UCHK:
            begin
                if (sts.s_zero)
                begin
                    case (tgt_reg)
                        TGT_N:
                        begin
                            nok_next   = 1'b0;
                            state_next = S_VLD;
                        end
                        TGT_V:
                        begin
                            vok_next   = 1'b0;
                            k_next     = '0;
                            state_next = S_LNEXT;
                        end
                        default:
                        begin
                            cmd.set_degen = 1'b1;
                            k_next        = k_reg + CNT_W'(1);
                            state_next    = S_LNEXT;
                        end
                    endcase
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_USQRT;
                end
            end

            S_USQRT:
            begin
                if (!sts.sqrt_busy)
                    state_next = S_UDIV;
            end

            S_UDIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_UDIVW;
            end

            S_UDIVW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.div_store = 1'b1;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next = 2'd0;
                        case (tgt_reg)
                            TGT_N:
                                state_next = S_VLD;
                            TGT_V:
                            begin
                                k_next     = '0;
                                state_next = S_LNEXT;
                            end
                            default:
                            begin
                                dstep_next = 4'd0;
                                state_next = S_DOT;
                            end
                        endcase
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_UDIV;
                    end
                end
            end

            S_VLD:
            begin
                cmd.wv_view = 1'b1;
                tgt_next    = TGT_V;
                comp_next   = 2'd0;
                state_next  = S_USQ;
            end

            // per-light loop head
            S_LNEXT:
            begin
                if (k_reg == lim)
                    state_next = S_FIN;
                else if (!nok_reg || !vok_reg)
                begin
                    cmd.set_degen = 1'b1;
                    k_next        = k_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LRD;
                end
            end

            S_LRD:
            begin
                cmd.wv_light = 1'b1;
                tgt_next     = TGT_L;
                comp_next    = 2'd0;
                state_next   = S_USQ;
            end

            S_DOT:
            begin
                cmd.dot_acc = 1'b1;
                if (dstep_reg == 4'd8)
                    state_next = S_CSM;
                else
                    dstep_next = dstep_reg + 4'd1;
            end

            S_CSM:
            begin
                cmd.cs_mul = 1'b1;
                state_next = S_CSF;
            end

            S_CSF:
            begin
                cmd.cs_fin = 1'b1;
                state_next = S_PWR;
            end

            S_PWR:
            begin
                if (sts.e_zero)
                    state_next = S_T1;
                else
                    cmd.pwr_step = 1'b1;
            end

            S_T1:
            begin
                cmd.term1  = 1'b1;
                state_next = S_T2;
            end

            S_T2:
            begin
                cmd.term2  = 1'b1;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_LNEXT;
            end

            // hand the result to the output register
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_ld = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            comp_reg   <= '0;
            tgt_reg    <= TGT_N;
            dstep_reg  <= '0;
            k_reg      <= '0;
            nok_reg    <= 1'b0;
            vok_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            active_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            tgt_reg   <= tgt_next;
            dstep_reg <= dstep_next;
            k_reg     <= k_next;
            nok_reg   <= nok_next;
            vok_reg   <= vok_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en && cfg_index == REG_ACTIVE)
                active_reg <= cfg_data[3:0];
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ov_reg;
    assign rd_addr   = IDX_W'(k_reg);

endmodule

// ----- hdl/phong_light_accumulator_core.sv -----
// phong_light_accumulator_core: top level, controller plus datapath
// depends on plc_pkg, plc_ctrl, plc_dpath
//
//   channel  direction  handshake             beat
//   in       input      in_valid / in_stall   one load or shade request
//   out      output     out_valid / out_stall one total_light, clipped, degenerate
//   cfg      input      cfg_wr_en             one register write, no stall
//
// per active light, a shade steps the power loop once per shininess bit up to the
// top set bit when the specular cosine is positive, and cuts the light short for
// a zero-length light vector or when N or V is zero. the time goes to the shared
// square root and divider that normalize N, V and each light vector.
// reset is asynchronous active low and clears control and config state;
// the light table is not cleared. a finished result waits in the output
// register while the next request is accepted.
module phong_light_accumulator_core
    import plc_pkg::*;
#(
    parameter int LIGHTS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [2:0]           light_slot,
    input  logic                 light_kind,
    input  logic [LEVEL_W-1:0]   light_level,
    input  logic [VEC_W-1:0]     vector_a,
    input  logic [VEC_W-1:0]     surface_normal,
    input  logic [VEC_W-1:0]     view_vector,
    input  logic [EXP_W-1:0]     shininess,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LEVEL_W-1:0]   total_light,
    output logic                 clipped,
    output logic                 degenerate,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int CNT_W = $clog2(LIGHTS + 1);

    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] rd_addr;

    plc_ctrl #(
        .LIGHTS (LIGHTS),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rd_addr   (rd_addr)
    );

    plc_dpath #(
        .LIGHTS (LIGHTS),
        .IDX_W  (IDX_W)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .rd_addr        (rd_addr),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .light_slot     (light_slot),
        .light_kind     (light_kind),
        .light_level    (light_level),
        .vector_a       (vector_a),
        .surface_normal (surface_normal),
        .view_vector    (view_vector),
        .shininess      (shininess),
        .total_light    (total_light),
        .clipped        (clipped),
        .degenerate     (degenerate)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench of phong_light_accumulator_core
// drives load and shade beats, predicts each result in-bench and checks every output beat
// depends on plc_pkg and phong_light_accumulator_core
module tb_top
    import plc_pkg::*;
();

    localparam int NLIGHT = 8;
    localparam int WDOG_LIMIT = 40000;

    typedef longint vec_t [3];

    typedef struct {
        logic               req;
        logic [2:0]         slot;
        logic               kind;
        logic [LEVEL_W-1:0] level;
        logic [VEC_W-1:0]   va;
        logic [VEC_W-1:0]   nrm;
        logic [VEC_W-1:0]   view;
        logic [EXP_W-1:0]   shin;
    } req_t;

    typedef struct {
        logic [LEVEL_W-1:0] total;
        logic               clip;
        logic               degen;
    } light_sum_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic [2:0] light_slot = '0;
    logic light_kind = 1'b0;
    logic [LEVEL_W-1:0] light_level = '0;
    logic [VEC_W-1:0] vector_a = '0;
    logic [VEC_W-1:0] surface_normal = '0;
    logic [VEC_W-1:0] view_vector = '0;
    logic [EXP_W-1:0] shininess = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [LEVEL_W-1:0] total_light;
    logic clipped;
    logic degenerate;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow of the block's light table and registers
    logic [VEC_W-1:0] shadow_vec [NLIGHT];
    logic [16:0]      shadow_par [NLIGHT];
    logic [15:0]      amb_q = '0;
    logic [3:0]       nact_q = '0;

    req_t       beat_q [$];
    light_sum_t sum_q [$];
    req_t       cur;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    bit  calm = 0;
    int  outs_seen = 0;
    int  errors = 0;
    int  quiet = 0;

    phong_light_accumulator_core #(.LIGHTS(NLIGHT)) dut (.*);

    always #10 clk = ~clk;

    // integer square root, bit by bit
    function automatic longint root_floor(input longint s_in);
        longint s, res, b;
        s = s_in;
        res = 0;
        b = longint'(1) << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void split_vec(input logic [VEC_W-1:0] v, output vec_t c);
        for (int i = 0; i < 3; i++)
            c[i] = longint'($signed(v[16*i +: 16]));
    endfunction

    // q1.14 unit vector, 0 for zero length
    function automatic bit make_unit(input vec_t v, output vec_t u);
        longint s, m, mag, q;
        s = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        if (s == 0)
            return 0;
        m = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            mag = v[i] < 0 ? -v[i] : v[i];
            q = (mag * 16384) / m;
            u[i] = v[i] < 0 ? -q : q;
        end
        return 1;
    endfunction

    function automatic longint dot3(input vec_t a, input vec_t b);
        return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    endfunction

    // expected result of one accepted beat; loads update the shadow table
    function automatic light_sum_t shade_point(input req_t r);
        light_sum_t o;
        vec_t pt, nv, vv, nu, vu, lv, lu;
        bit nok, vok;
        longint sum, lvl, cd, p, dnl, dnv, dlv, cs, c, b, e;
        int n;
        o = '{default: '0};
        if (r.req == REQ_LOAD)
        begin
            shadow_vec[r.slot] = r.va;
            shadow_par[r.slot] = {r.kind, r.level};
            return o;
        end
        split_vec(r.va, pt);
        split_vec(r.nrm, nv);
        split_vec(r.view, vv);
        nok = make_unit(nv, nu);
        vok = make_unit(vv, vu);
        n = nact_q > NLIGHT ? NLIGHT : nact_q;
        sum = amb_q;
        for (int k = 0; k < n; k++)
        begin
            split_vec(shadow_vec[k], lv);
            lvl = shadow_par[k][15:0];
            cd = 0;
            p = 0;
            if (shadow_par[k][16] == KIND_POINT)
                for (int i = 0; i < 3; i++) lv[i] = lv[i] - pt[i];
            if (!nok || !vok || !make_unit(lv, lu))
            begin
                o.degen = 1'b1;
                continue;
            end
            dnl = dot3(nu, lu);
            dnv = dot3(nu, vu);
            dlv = dot3(lu, vu);
            if (dnl > 0)
            begin
                cd = dnl >> 14;
                if (cd > 16384) cd = 16384;
            end
            cs = 2 * dnl * dnv - dlv * 268435456;
            if (cs > 0)
            begin
                c = cs >> 42;
                if (c > 16384) c = 16384;
                // power by squaring from the low exponent bit
                p = 16384;
                b = c;
                e = r.shin;
                while (e != 0)
                begin
                    if (e & 1) p = (p * b) >> 14;
                    b = (b * b) >> 14;
                    e = e >> 1;
                end
            end
            sum = sum + ((lvl * cd) >> 14) + ((lvl * p) >> 14);
        end
        if (sum > 65535)
        begin
            o.total = 16'hFFFF;
            o.clip = 1'b1;
        end
        else
            o.total = sum[15:0];
        return o;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'h0000;
            default: return 16'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec();
        if ($urandom_range(0, 40) == 0)
            return '0;
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    function automatic req_t rand_beat();
        req_t r;
        r.req = ($urandom_range(0, 4) == 0) ? REQ_LOAD : REQ_SHADE;
        r.slot = 3'($urandom);
        r.kind = 1'($urandom);
        r.level = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        r.va = rand_vec();
        r.nrm = rand_vec();
        r.view = rand_vec();
        case ($urandom_range(0, 3))
            0: r.shin = 10'($urandom);
            1: r.shin = '0;
            default: r.shin = 10'($urandom_range(1, 64));
        endcase
        return r;
    endfunction

    function automatic req_t mk_beat(input logic rq, input logic [2:0] sl, input logic kd,
                                     input logic [15:0] lv, input logic [VEC_W-1:0] a,
                                     input logic [VEC_W-1:0] nm, input logic [VEC_W-1:0] vw,
                                     input logic [EXP_W-1:0] sh);
        req_t r;
        r.req = rq; r.slot = sl; r.kind = kd; r.level = lv;
        r.va = a; r.nrm = nm; r.view = vw; r.shin = sh;
        return r;
    endfunction

    // input driver: one beat in flight, held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sum_q.push_back(shade_point(cur));
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    cur = beat_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur.req;
                    light_slot <= cur.slot;
                    light_kind <= cur.kind;
                    light_level <= cur.level;
                    vector_a <= cur.va;
                    surface_normal <= cur.nrm;
                    view_vector <= cur.view;
                    shininess <= cur.shin;
                    if (!calm && $urandom_range(0, 4) == 0)
                        gap_left <= $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output stall: random bursts plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && outs_seen >= 40)
            begin
                hold_done <= 1'b1;
                hold_left <= 3000;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        light_sum_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            outs_seen <= outs_seen + 1;
            if (sum_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = sum_q.pop_front();
                if (total_light !== want.total)
                begin
                    $error("total_light expected %0d got %0d", want.total, total_light);
                    errors++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped expected %0d got %0d", want.clip, clipped);
                    errors++;
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate expected %0d got %0d", want.degen, degenerate);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_AMBIENT)
            amb_q = val;
        else
            nact_q = val[3:0];
    endtask

    // checked at the falling edge so queue and valid are settled
    task automatic drain();
        while (beat_q.size() > 0 || in_valid || gap_left > 0 || sum_q.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    // stimulus phases
    initial
    begin
        logic [15:0] amb_set [6];
        logic [15:0] nact_set [6];
        amb_set = '{16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd4096, 16'd300};
        nact_set = '{16'd1, 16'd8, 16'd2, 16'd15, 16'd0, 16'd3};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // fill every slot before anything reads it
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd0, 1'b0, 16'hFFFF, 48'h0400_0400_0400, '1, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd1, 1'b1, 16'h0000, 48'h8000_7FFF_8000, '0, '1, '1));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd2, 1'b1, 16'h4000, 48'h0100_0000_0000, '0, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd3, 1'b0, 16'h2000, 48'h0000_0000_0000, '0, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd4, 1'b1, 16'h8000, 48'h7FFF_7FFF_7FFF, '0, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd5, 1'b0, 16'h1000, 48'hFF00_0100_0000, '0, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd6, 1'b1, 16'hC000, 48'h8000_8000_8000, '0, '0, 0));
        beat_q.push_back(mk_beat(REQ_LOAD, 3'd7, 1'b0, 16'h0001, 48'h0001_0000_0000, '0, '0, 0));
        // no active lights: ambient only, even with zero vectors
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0, 48'h0, 48'h0, 48'h0, 10'd5));
        drain();
        cfg_write(REG_AMBIENT, 16'hFFFF);
        cfg_write(REG_ACTIVE, 16'd8);
        // saturation, zero normal, zero view, zero light vector, exponents zero and one
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0, 48'h0100_0100_0100, 48'h0100_0100_0100, 10'd0));
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0, 48'h0, 48'h0100_0000_0000, 10'd1));
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0, 48'h0100_0000_0000, 48'h0, 10'd1));
        drain();
        cfg_write(REG_AMBIENT, 16'd0);
        cfg_write(REG_ACTIVE, 16'd4);
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0, 48'h0100_0100_0100, 48'h0100_0100_0100, 10'd1023));
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0400_0400_0400, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 10'd2));
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0100, 48'h0000_0000_0100, 10'd0));
        beat_q.push_back(mk_beat(REQ_SHADE, 3'd0, 1'b0, 16'h0,
                                 48'h0, 48'h0000_0000_0100, 48'h0000_0000_FF00, 10'd1));
        drain();
        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 5);
            cfg_write(REG_AMBIENT, amb_set[ph]);
            cfg_write(REG_ACTIVE, nact_set[ph]);
            for (int i = 0; i < 215; i++)
                beat_q.push_back(rand_beat());
            drain();
        end
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
